// ----- src/chm_pkg.sv -----
// Package for the tag-only cache model: sizes, register indexes and the
// front-to-back request record. No dependencies.
package chm_pkg;
    localparam int unsigned MaxLines  = 64;
    localparam int unsigned LineIdxW  = 6;
    localparam int unsigned OffBits   = 6;
    localparam int unsigned AddrW     = 32;
    localparam int unsigned TagW      = AddrW - OffBits;
    localparam int unsigned CntW      = 64;
    localparam int unsigned CfgIdxW   = 2;
    localparam int unsigned CfgDataW  = 4;
    localparam int unsigned SizeLogW  = 4;
    localparam int unsigned QDepth    = 2;
    localparam int unsigned QPtrW     = 1;

    localparam logic [CfgIdxW-1:0] RegMapping = 2'd0;
    localparam logic [CfgIdxW-1:0] RegSplit   = 2'd1;
    localparam logic [CfgIdxW-1:0] RegSize    = 2'd2;

    // One classified access as passed from front to back.
    typedef struct packed {
        logic                assoc;
        logic                use_data_tail;
        logic [LineIdxW-1:0] base;
        logic [LineIdxW-1:0] store_mask;
        logic [LineIdxW-1:0] dm_idx;
        logic [TagW-1:0]     tag;
    } t_req;
endpackage

// ----- src/chm_front.sv -----
// Front end: accepts accesses, works out store base, size and tag and
// queues them for the back end. Depends on chm_pkg.
module chm_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [chm_pkg::AddrW-1:0]   i_mem_address,
    input  logic                        i_is_data,
    input  logic                        i_mapping_mode,
    input  logic                        i_split_mode,
    input  logic [chm_pkg::SizeLogW-1:0] i_cache_size_log2,
    output logic                        o_req_valid,
    input  logic                        i_req_take,
    output chm_pkg::t_req               o_req
);
    import chm_pkg::*;

    t_req                r_q [QDepth];
    logic [QPtrW-1:0]    r_wp, r_rp;
    logic [QPtrW:0]      r_cnt;
    t_req                n_req;
    logic [2:0]          lines_log;
    logic [2:0]          store_log;
    logic [LineIdxW-1:0] mask;
    logic                push_ok, take_ok;

    always_comb begin
        if (i_cache_size_log2 < 4'd7) lines_log = 3'd1;
        else if (i_cache_size_log2 > 4'd12) lines_log = 3'd6;
        else lines_log = 3'(i_cache_size_log2 - 4'd6);
        store_log = i_split_mode ? lines_log - 3'd1 : lines_log;
        mask = LineIdxW'((7'd1 << store_log) - 7'd1);
        n_req.assoc         = i_mapping_mode;
        n_req.use_data_tail = i_split_mode & i_is_data;
        n_req.base          = n_req.use_data_tail ? mask + 6'd1 : '0;
        n_req.store_mask    = mask;
        n_req.dm_idx        = i_mem_address[OffBits +: LineIdxW] & mask;
        n_req.tag           = i_mapping_mode ? i_mem_address[AddrW-1:OffBits]
                                             : TagW'(i_mem_address >> (OffBits + store_log));
    end

    assign o_full      = (r_cnt == (QPtrW+1)'(QDepth));
    assign o_req_valid = (r_cnt != '0);
    assign o_req       = r_q[r_rp];
    assign push_ok     = i_push && !o_full;
    assign take_ok     = i_req_take && o_req_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) r_q[r_wp] <= n_req;
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) r_wp <= r_wp + 1'b1;
            if (take_ok) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPtrW+1)'(push_ok) - (QPtrW+1)'(take_ok);
        end
    end
endmodule

// ----- src/chm_back.sv -----
// Back end: tag store lookup (direct index or sequential scan over a registered
// tag read), refill, FIFO tails, counters and the one-entry result register.
// Depends on chm_pkg.
module chm_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    output logic                      o_req_take,
    input  chm_pkg::t_req             i_req,
    output logic                      o_empty,
    input  logic                      i_pop,
    output logic                      o_hit,
    output logic [chm_pkg::CntW-1:0]  o_access_count,
    output logic [chm_pkg::CntW-1:0]  o_hit_count
);
    import chm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state              r_state;
    t_req                r_req;
    logic [LineIdxW-1:0] r_i;
    logic                r_found;
    logic [MaxLines-1:0] r_valid;
    logic [TagW-1:0]     r_tag [MaxLines];
    logic [TagW-1:0]     r_rd_tag;
    logic                r_rd_valid;
    logic [LineIdxW-1:0] r_itail, r_dtail;
    logic [CntW-1:0]     r_acc, r_hits;
    logic                r_out_valid;
    logic                r_hit;
    logic [LineIdxW-1:0] rd_line, wr_line, tail, slot;
    logic                match, last;

    // read the first line of a new request while idle, then the next line each scan cycle
    assign rd_line = (r_state == S_IDLE)
                   ? (i_req.assoc ? i_req.base : i_req.base + i_req.dm_idx)
                   : r_req.base + r_i + 6'd1;
    assign tail    = r_req.use_data_tail ? r_dtail : r_itail;
    assign slot    = tail & r_req.store_mask;
    assign wr_line = r_req.assoc ? r_req.base + slot : r_req.base + r_req.dm_idx;
    assign match   = r_rd_valid && (r_rd_tag == r_req.tag);
    assign last    = !r_req.assoc || (r_i == r_req.store_mask);

    assign o_req_take     = (r_state == S_IDLE);
    assign o_empty        = !r_out_valid;
    assign o_hit          = r_hit;
    assign o_access_count = r_acc;
    assign o_hit_count    = r_hits;

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req_valid) r_req <= i_req;
        r_rd_tag   <= r_tag[rd_line];
        r_rd_valid <= r_valid[rd_line];
        if (r_state == S_SCAN && (match || last) && !(match || r_found)) begin
            r_tag[wr_line] <= r_req.tag;
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_found     <= 1'b0;
            r_valid     <= '0;
            r_itail     <= '0;
            r_dtail     <= '0;
            r_acc       <= '0;
            r_hits      <= '0;
            r_out_valid <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            if (i_pop && r_out_valid && r_state != S_DONE) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_i     <= '0;
                    r_found <= 1'b0;
                    if (i_req_valid) r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // advance one line a cycle until a hit or the store end
                    if (match || last) begin
                        r_found <= match;
                        if (!match) begin
                            r_valid[wr_line] <= 1'b1;
                            if (r_req.assoc) begin
                                if (r_req.use_data_tail)
                                    r_dtail <= (slot + 6'd1) & r_req.store_mask;
                                else
                                    r_itail <= (slot + 6'd1) & r_req.store_mask;
                            end
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_i <= r_i + 6'd1;
                    end
                end
                S_DONE: begin
                    // hold until the result register is free
                    if (!r_out_valid || i_pop) begin
                        r_out_valid <= 1'b1;
                        r_hit       <= r_found;
                        r_acc       <= r_acc + 64'd1;
                        r_hits      <= r_hits + CntW'(r_found);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- src/cache_hit_miss_model.sv -----
// Top level of the tag-only cache model: configuration registers and the
// front/back split. Depends on chm_pkg, chm_front and chm_back.
//
// Tag-only model of a cache of up to 64 lines with 64-byte lines. Each access
// beat gives a byte address and an instruction/data flag and yields one result
// beat: hit flag plus running access and hit counts (64-bit, wrapping). A
// direct-mapped access compares the one indexed tag; a fully associative access
// scans the selected store one tag per cycle, up to the store size, using the
// single sequential tag compare in the back end. A two-entry queue lets
// the front accept new beats while the back is busy and a result register
// holds a finished beat until popped. Write configuration only when idle;
// lines, tags and FIFO tails survive configuration changes.
module cache_hit_miss_model (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [chm_pkg::AddrW-1:0]        i_mem_address,
    input  logic                             i_is_data,
    output logic                             empty,
    input  logic                             pop,
    output logic                             o_hit,
    output logic [chm_pkg::CntW-1:0]         o_access_count,
    output logic [chm_pkg::CntW-1:0]         o_hit_count,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [chm_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [chm_pkg::CfgDataW-1:0]     i_cfg_data
);
    import chm_pkg::*;

    logic                r_mapping_mode;
    logic                r_split_mode;
    logic [SizeLogW-1:0] r_size_log2;
    logic                req_valid, req_take;
    t_req                req;

    assign o_cfg_ready = 1'b1;

    // take a configuration beat whenever offered; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mapping_mode <= 1'b0;
            r_split_mode   <= 1'b0;
            r_size_log2    <= 4'd12;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                RegMapping: r_mapping_mode <= i_cfg_data[0];
                RegSplit:   r_split_mode   <= i_cfg_data[0];
                RegSize:    r_size_log2    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    chm_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_mem_address    (i_mem_address),
        .i_is_data        (i_is_data),
        .i_mapping_mode   (r_mapping_mode),
        .i_split_mode     (r_split_mode),
        .i_cache_size_log2(r_size_log2),
        .o_req_valid      (req_valid),
        .i_req_take       (req_take),
        .o_req            (req)
    );

    chm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (req_valid),
        .o_req_take     (req_take),
        .i_req          (req),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_hit          (o_hit),
        .o_access_count (o_access_count),
        .o_hit_count    (o_hit_count)
    );
endmodule
